// ----- design/mtf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_pkg
// Shared operation codes and result type of the move-to-front list.
// ----------------------------------------------------------------------------
package mtf_pkg;

    // Operation selector carried on the input tuser bit
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // Width of the input tdata and output tdata buses
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 16;

    // One result transaction as produced by the controller
    typedef struct packed {
        logic [4:0] entry_count;
        logic       overflow;
        logic [3:0] old_position;
        logic       found;
    } mtf_result_t;

endpackage

// ----- design/mtf_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mtf_mem #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [31:0]       wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [31:0]       rd_data
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/mtf_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_ctrl
// Sequencer: ring-buffer head and count, front-to-back scan with shift-back
// write-behind, and result formation.
// ----------------------------------------------------------------------------
module mtf_ctrl #(
    parameter int LIST_DEPTH = 16,
    parameter int PW         = 4,
    parameter int CW         = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_func,
    input  logic [31:0]         in_value,
    output logic                res_valid,
    output mtf_pkg::mtf_result_t res,
    input  logic                out_free,
    output logic                wr_en,
    output logic [PW-1:0]       wr_addr,
    output logic [31:0]         wr_data,
    output logic [PW-1:0]       rd_addr,
    input  logic [31:0]         rd_data
);
    import mtf_pkg::*;

    localparam logic [PW:0]   DEPTH_W   = (PW+1)'(LIST_DEPTH);
    localparam logic [PW-1:0] LAST_SLOT = PW'(LIST_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL  = CW'(LIST_DEPTH);
    localparam logic [CW-1:0] CNT_ONE   = CW'(1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_TAIL,
        S_DONE
    } state_t;

    state_t      state_reg;
    logic [PW-1:0] head_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    logic [31:0]   val_reg;
    logic [31:0]   prev_reg;
    mtf_result_t   res_reg;

    logic [PW-1:0] head_dec;
    logic [CW-1:0] idx_inc;
    logic          hit;
    logic          last;

    // Ring slot of logical position off behind base
    function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] base,
                                              input logic [CW-1:0] off);
        logic [PW:0] sum;
        sum = {1'b0, base} + (PW+1)'(off);
        if (sum >= DEPTH_W)
        begin
            sum = sum - DEPTH_W;
        end
        return sum[PW-1:0];
    endfunction

    assign head_dec = (head_reg == '0) ? LAST_SLOT : head_reg - PW'(1);
    assign idx_inc  = idx_reg + CNT_ONE;
    assign hit      = (rd_data == val_reg);
    assign last     = (idx_inc == count_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    // Memory port control
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = head_reg;
        wr_data = val_reg;
        rd_addr = head_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_func == OP_INSERT && count_reg != CNT_FULL)
                begin
                    wr_en   = 1'b1;
                    wr_addr = head_dec;
                    wr_data = in_value;
                end
            end
            S_SCAN:
            begin
                rd_addr = slot_of(head_reg, idx_inc);
                if (idx_reg != '0)
                begin
                    // write entry idx-1 one place back
                    wr_en   = 1'b1;
                    wr_addr = slot_of(head_reg, idx_reg);
                    wr_data = prev_reg;
                end
            end
            S_TAIL:
            begin
                wr_en   = 1'b1;
                wr_addr = slot_of(head_reg, count_reg);
                wr_data = prev_reg;
            end
            S_DONE:
            begin
                // hit goes to the front slot
                if (res_reg.found)
                begin
                    wr_en   = 1'b1;
                    wr_addr = head_reg;
                    wr_data = val_reg;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
            val_reg   <= '0;
            prev_reg  <= '0;
            res_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        val_reg <= in_value;
                        idx_reg <= '0;
                        if (in_func == OP_SEARCH)
                        begin
                            res_reg   <= {5'(count_reg), 1'b0, 4'd0, 1'b0};
                            state_reg <= (count_reg == '0) ? S_DONE : S_SCAN;
                        end
                        else
                        begin
                            if (count_reg == CNT_FULL)
                            begin
                                res_reg <= {5'(count_reg), 1'b1, 4'd0, 1'b0};
                            end
                            else
                            begin
                                head_reg  <= head_dec;
                                count_reg <= count_reg + CNT_ONE;
                                res_reg   <= {5'(count_reg + CNT_ONE), 1'b0, 4'd0, 1'b0};
                            end
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (hit)
                    begin
                        res_reg   <= {res_reg.entry_count, 1'b0, 4'(idx_reg), 1'b1};
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        prev_reg <= rd_data;
                        idx_reg  <= idx_inc;
                        if (last)
                        begin
                            state_reg <= S_TAIL;
                        end
                    end
                end
                S_TAIL:
                begin
                    // whole list moved one slot back: advance the head
                    head_reg  <= slot_of(head_reg, CNT_ONE);
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- design/move_to_front_list.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// move_to_front_list
// Bounded move-to-front self-organizing list of signed 32-bit values.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis_*: one transaction per operation. tuser selects the
//   operation (0 insert at front, 1 search and move to front), tdata carries
//   the value. Master channel m_axis_*: exactly one result transaction per
//   operation, in order.
//   Entries live in a ring buffer in one synchronous RAM; the head pointer
//   moves back on insert, so an insert costs no shifting.
//   A search reads one entry per cycle from the front and, while it scans,
//   writes each entry it passed one slot back. A hit writes the entry before
//   it one slot back, then the value at the front slot while the result
//   waits; a miss writes the last entry behind the list and advances the
//   head, which restores the original order.
// Flow: operations do not overlap; a new one is accepted only in idle, once
//   the controller has handed the last result to the output register.
// Reset: the list is empty after reset; the RAM is not cleared, since only
//   entries below the count are ever used.
// Stall: the result is held in the output register; the next operation is
//   accepted while it waits, and its own result waits until the slot frees.
// ----------------------------------------------------------------------------
module move_to_front_list #(
    parameter int LIST_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] item_value
    input  logic        s_axis_tuser,   // [0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] found, [4:1] old_position, [5] overflow, [10:6] entry_count, zero fill
    output logic [15:0] m_axis_tdata
);
    import mtf_pkg::*;

    localparam int PW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);

    logic          wr_en;
    logic [PW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic [PW-1:0] rd_addr;
    logic [31:0]   rd_data;

    logic          res_valid;
    mtf_result_t   res;
    logic          out_free;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    mtf_mem #(
        .DEPTH  (LIST_DEPTH),
        .ADDR_W (PW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mtf_ctrl #(
        .LIST_DEPTH (LIST_DEPTH),
        .PW         (PW),
        .CW         (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_func   (s_axis_tuser),
        .in_value  (s_axis_tdata),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    // Output slot is free when empty or drained in this cycle
    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the result fields, lowest field first, zero fill to 16 bits
    always_ff @(posedge clk)
    begin
        if (res_valid && out_free)
        begin
            out_data_reg <= OUT_DATA_W'(res);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ----- design/mtf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_checker
// Port-level assertions for the move-to-front list, bound to the top level.
// ----------------------------------------------------------------------------
module mtf_checker #(
    parameter int LIST_DEPTH = 16
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    localparam logic [4:0] FULL_COUNT = 5'(LIST_DEPTH);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Hold an offered operation until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=>
            s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
        else $error("offered operation changed before acceptance");

    // A hit is never an overflow
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[5]))
        else $error("found and overflow both set");

    // Position only reported on a hit
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[4:1] == 4'd0)
        else $error("old_position nonzero without a hit");

    // Overflow only on a full list
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[5] |-> m_axis_tdata[10:6] == FULL_COUNT)
        else $error("overflow with list not full");

endmodule

bind move_to_front_list mtf_checker #(
    .LIST_DEPTH (LIST_DEPTH)
) u_mtf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
